// ===== sv/pli_pkg.sv =====
// Shared constants and types for the piecewise linear interpolator.
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int ENTRY_W    = 64;

	// Operation codes on func
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Clamp codes on clamp_code
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_LOW  = 2'd1;
	localparam logic [1:0] CLAMP_HIGH = 2'd2;

	// Quotient magnitude limit, 2^33
	localparam logic [33:0] QUOT_CAP = 34'h2_0000_0000;

	typedef struct packed {
		logic        start;
		logic [32:0] mul_a;
		logic [32:0] mul_b;
		logic [32:0] div_d;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] quot;
	} md_rsp_t;

endpackage

// ===== sv/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator over a loaded breakpoint table.
//
// Input channel (in_valid / in_stall): func selects a load or a query. A load
// writes x_value, y_value into slot point_index. A query looks up x_value
// against the first point_count breakpoints.
// Output channel (out_valid / out_stall): one result_value and clamp_code per
// query, none per load.
// Configuration: point_count is written through cfg_valid / cfg_ready; ready is
// always high. Write it only while the block is idle.
// A query compares against the first breakpoint (clamped below), then the last
// (clamped above), then bisects in k <= ceil(log2(point_count - 1)) steps,
// each reading the table in S_BIS and comparing in S_BCMP. An exact hit
// returns that y; otherwise the shared adder runs a multiply, an overflow check
// and a divide, and the divide is skipped when the quotient overflows the cap.
// The input is released in the same cycle that out_valid rises.
// The input is stalled for the whole query. A finished result sits in the
// output register while the receiver stalls; the next item is taken meanwhile,
// and a later query waits before its own result if that register is still full.
// Reset clears the control state and sets point_count to 1; the table holds
// nothing defined until loaded.
module piecewise_linear_interpolator import pli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [5:0]         point_index,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         clamp_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         point_count
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK0  = 3'd1;
	localparam logic [2:0] S_CHKN  = 3'd2;
	localparam logic [2:0] S_BIS   = 3'd3;
	localparam logic [2:0] S_BCMP  = 3'd4;
	localparam logic [2:0] S_END   = 3'd5;
	localparam logic [2:0] S_ARITH = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [6:0]         pc_q;
	logic signed [31:0] v_q;
	logic signed [31:0] xi_q, yi_q, xj_q, yj_q;
	logic [AW-1:0]      i_q, j_q, nm1_q;
	logic               neg_q;
	logic [31:0]        res_q;
	logic [1:0]         code_q;
	logic               out_valid_q;
	logic [31:0]        out_res_q;
	logic [1:0]         out_code_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic signed [31:0] ent_x, ent_y;
	logic [AW-1:0]      nm1;
	logic [AW:0]        mid_sum;
	logic [AW-1:0]      mid;
	logic               bis_more;
	logic signed [32:0] dy, dv, dx;
	logic [32:0]        mag_dy, mag_dv, mag_dx;
	logic               out_load;
	logic [34:0]        sq;
	logic [35:0]        sum36;
	logic [31:0]        sat;
	md_req_t            md_req;
	md_rsp_t            md_rsp;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign ram_we    = accept && (func == FUNC_LOAD) && (32'(point_index) < MAX_POINTS);

	assign ent_x = ram_rdata[63:32];
	assign ent_y = ram_rdata[31:0];

	// Effective last index, with point_count held to 1..MAX_POINTS
	always_comb begin
		if (pc_q == 7'd0) begin
			nm1 = '0;
		end else if (32'(pc_q) > MAX_POINTS) begin
			nm1 = AW'(MAX_POINTS - 1);
		end else begin
			nm1 = AW'(pc_q - 7'd1);
		end
	end

	assign mid_sum  = {1'b0, i_q} + {1'b0, j_q};
	assign mid      = mid_sum[AW:1];
	assign bis_more = ({1'b0, i_q} + {{AW{1'b0}}, 1'b1}) < {1'b0, j_q};

	always_comb begin
		case (state_q)
			S_IDLE:  ram_addr = (func == FUNC_QUERY) ? '0 : AW'(point_index);
			S_CHK0:  ram_addr = nm1_q;
			S_BIS:   ram_addr = mid;
			default: ram_addr = '0;
		endcase
	end

	pli_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({x_value, y_value}),
		.rdata(ram_rdata)
	);

	// Interval differences and their magnitudes
	always_comb begin
		dy     = {yj_q[31], yj_q} - {yi_q[31], yi_q};
		dv     = {v_q[31], v_q} - {xi_q[31], xi_q};
		dx     = {xj_q[31], xj_q} - {xi_q[31], xi_q};
		mag_dy = dy[32] ? 33'(-dy) : 33'(dy);
		mag_dv = dv[32] ? 33'(-dv) : 33'(dv);
		mag_dx = dx[32] ? 33'(-dx) : 33'(dx);
	end

	assign md_req.start = (state_q == S_END) && (v_q != xj_q) && (v_q != xi_q) && (dx != '0);
	assign md_req.mul_a = mag_dy;
	assign md_req.mul_b = mag_dv;
	assign md_req.div_d = mag_dx;

	pli_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// Apply sign, add to y_i and saturate to 32 bits
	always_comb begin
		sq    = neg_q ? 35'(-{1'b0, md_rsp.quot}) : {1'b0, md_rsp.quot};
		sum36 = {{4{yi_q[31]}}, yi_q} + {sq[34], sq};
		if (sum36[35:31] == 5'b00000 || sum36[35:31] == 5'b11111) begin
			sat = sum36[31:0];
		end else if (sum36[35]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7FFF_FFFF;
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= 7'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pc_q <= point_count;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && func == FUNC_QUERY) begin
						state_q <= S_CHK0;
					end
				end
				S_CHK0: begin
					state_q <= (v_q < ent_x) ? S_DONE : S_CHKN;
				end
				S_CHKN: begin
					state_q <= (v_q > ent_x) ? S_DONE : S_BIS;
				end
				S_BIS: begin
					state_q <= bis_more ? S_BCMP : S_END;
				end
				S_BCMP: begin
					state_q <= S_BIS;
				end
				S_END: begin
					state_q <= md_req.start ? S_ARITH : S_DONE;
				end
				S_ARITH: begin
					if (md_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q  <= res_q;
			out_code_q <= code_q;
		end
		case (state_q)
			S_IDLE: begin
				v_q   <= x_value;
				nm1_q <= nm1;
				i_q   <= '0;
				j_q   <= nm1;
			end
			S_CHK0: begin
				xi_q   <= ent_x;
				yi_q   <= ent_y;
				res_q  <= ent_y;
				code_q <= CLAMP_LOW;
			end
			S_CHKN: begin
				xj_q   <= ent_x;
				yj_q   <= ent_y;
				res_q  <= ent_y;
				code_q <= CLAMP_HIGH;
			end
			S_BIS: begin
				i_q <= i_q;
			end
			S_BCMP: begin
				// Narrow the interval toward the side holding the query
				if (v_q < ent_x) begin
					j_q  <= i_q + AW'((j_q - i_q) >> 1);
					xj_q <= ent_x;
					yj_q <= ent_y;
				end else begin
					i_q  <= i_q + AW'((j_q - i_q) >> 1);
					xi_q <= ent_x;
					yi_q <= ent_y;
				end
			end
			S_END: begin
				code_q <= CLAMP_NONE;
				neg_q  <= dy[32] ^ dv[32] ^ dx[32];
				if (v_q == xj_q) begin
					res_q <= yj_q;
				end else begin
					res_q <= yi_q;
				end
			end
			S_ARITH: begin
				if (md_rsp.done) begin
					res_q <= sat;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign clamp_code   = out_code_q;

endmodule

// ===== sv/pli_ram.sv =====
// Generic single-port RAM with registered read data.
module pli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/pli_muldiv.sv =====
// Bit-serial multiply then restoring divide on one shared adder.
module pli_muldiv import pli_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_MUL  = 3'd1;
	localparam logic [2:0] M_CHK  = 3'd2;
	localparam logic [2:0] M_DIV  = 3'd3;
	localparam logic [2:0] M_DONE = 3'd4;

	localparam logic [5:0] MUL_LAST = 6'd32;
	localparam logic [5:0] DIV_LAST = 6'd33;

	logic [2:0]  st_q;
	logic [5:0]  cnt_q;
	logic [32:0] a_q;
	logic [32:0] d_q;
	logic [32:0] hi_q;
	logic [33:0] lo_q;

	logic [33:0] opa;
	logic [33:0] opb;
	logic        sub;
	logic [34:0] sum;

	// Shared adder: accumulate in multiply, trial subtract in divide
	always_comb begin
		opa = '0;
		opb = '0;
		sub = 1'b0;
		case (st_q)
			M_MUL: begin
				opa = {1'b0, hi_q};
				opb = lo_q[0] ? {1'b0, a_q} : 34'd0;
			end
			M_CHK: begin
				opa = {2'b00, hi_q[32:1]};
				opb = {1'b0, d_q};
				sub = 1'b1;
			end
			M_DIV: begin
				opa = {hi_q, lo_q[33]};
				opb = {1'b0, d_q};
				sub = 1'b1;
			end
			default: begin
				opa = '0;
			end
		endcase
		sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {34'd0, sub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= M_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				M_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						st_q <= M_MUL;
					end
				end
				M_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						st_q <= M_CHK;
					end
				end
				M_CHK: begin
					cnt_q <= '0;
					st_q  <= sum[34] ? M_DONE : M_DIV;
				end
				M_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						st_q <= M_DONE;
					end
				end
				M_DONE: begin
					st_q <= M_IDLE;
				end
				default: begin
					st_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (req.start) begin
					a_q  <= req.mul_a;
					d_q  <= req.div_d;
					hi_q <= '0;
					lo_q <= {1'b0, req.mul_b};
				end
			end
			M_MUL: begin
				hi_q <= sum[33:1];
				lo_q <= {1'b0, sum[0], lo_q[32:1]};
			end
			M_CHK: begin
				// High part already at or above the divisor: quotient overflows the cap
				if (sum[34]) begin
					lo_q <= QUOT_CAP;
				end else begin
					hi_q <= {1'b0, hi_q[32:1]};
					lo_q <= {hi_q[0], lo_q[32:0]};
				end
			end
			M_DIV: begin
				hi_q <= sum[34] ? sum[32:0] : {hi_q[31:0], lo_q[33]};
				lo_q <= {lo_q[32:0], sum[34]};
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign rsp.done = (st_q == M_DONE);
	assign rsp.quot = (lo_q > QUOT_CAP) ? QUOT_CAP : lo_q;

endmodule

// ===== sv/pli_checker.sv =====
// Port-level checker for the piecewise linear interpolator, bound to the top level.
module pli_checker import pli_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        func,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_value,
	input logic [1:0]  clamp_code
);

	// A load finishes in its own transfer cycle
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_LOAD |=> !in_stall)
		else $error("input stalled after a load transfer");

	// A query holds off the next item while it is worked on
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_QUERY |=> in_stall)
		else $error("input not stalled after a query transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_value) && $stable(clamp_code))
		else $error("result changed while stalled");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
